@@ hw/rtl/mrf_pkg.sv @@
package mrf_pkg;

	// input operation codes
	localparam logic [2:0] OP_READ      = 3'd0;
	localparam logic [2:0] OP_WRITE_ONE = 3'd1;
	localparam logic [2:0] OP_WRITE_HDR = 3'd2;
	localparam logic [2:0] OP_DATA      = 3'd3;
	localparam logic [2:0] OP_RESP      = 3'd4;

	// result kinds
	localparam logic [1:0] KIND_TX     = 2'd0;
	localparam logic [1:0] KIND_WORD   = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	// Modbus function codes
	localparam logic [7:0] FC_READ_HOLD  = 8'd3;
	localparam logic [7:0] FC_WRITE_ONE  = 8'd6;
	localparam logic [7:0] FC_WRITE_MULT = 8'd16;

	localparam logic [15:0] CRC_SEED = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam logic [6:0]  MAX_REGS = 7'd125;
	localparam logic [7:0]  RX_CNT_MAX = 8'd255;
	localparam logic [7:0]  FIRST_DATA_POS = 8'd3;

	// frame byte slots in one job
	localparam int JOB_BYTES = 8;
	localparam int STEP_W    = $clog2(JOB_BYTES);

	// queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic [1:0] {
		PEND_NONE   = 2'd0,
		PEND_READ   = 2'd1,
		PEND_SINGLE = 2'd2,
		PEND_MULTI  = 2'd3
	} pend_t;

	// one unit of work handed from front to back
	typedef struct packed {
		logic                           is_rx;
		logic [STEP_W:0]                nbytes;
		logic [JOB_BYTES-1:0][7:0]      bytes;
		logic                           crc_init;
		logic                           send_crc;
		logic                           has_word;
		logic [15:0]                    word;
		logic [6:0]                     widx;
		logic                           has_status;
		logic                           ok;
	} job_t;

	// one byte through the reflected CRC-16
	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = {1'b0, c[15:1]} ^ CRC_POLY;
			end else begin
				c = {1'b0, c[15:1]};
			end
		end
		return c;
	endfunction

endpackage

@@ hw/rtl/mrf_front.sv @@
module mrf_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [7:0]         cfg_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         operation,
	input  logic [15:0]        start_register,
	input  logic [6:0]         register_count,
	input  logic [15:0]        data_word,
	input  logic [7:0]         rx_byte,
	input  logic               last_item,
	input  logic               q_full,
	output logic               q_push,
	output mrf_pkg::job_t      q_job
);
	import mrf_pkg::*;

	logic [7:0]  slave_address_q;
	logic [15:0] rx_crc_q;
	logic [7:0]  rx_cnt_q;
	logic [7:0]  hold_q;
	logic [6:0]  exp_words_q;
	pend_t       pending_q;

	logic        accept;
	logic [15:0] rx_crc_d;
	logic [7:0]  rx_cnt_d;
	logic [7:0]  hold_d;
	logic [6:0]  exp_words_d;
	pend_t       pending_d;
	logic        push;
	job_t        job;

	logic [15:0] crc_next;
	logic [7:0]  cnt_next;
	logic [7:0]  dpos;
	logic [6:0]  widx;
	logic        in_words;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	// receive-side helpers
	assign crc_next = crc_feed(rx_crc_q, rx_byte);
	assign cnt_next = (rx_cnt_q != RX_CNT_MAX) ? rx_cnt_q + 8'd1 : rx_cnt_q;
	assign dpos     = rx_cnt_q - FIRST_DATA_POS;
	assign widx     = dpos[7:1];
	assign in_words = (pending_q == PEND_READ) && (rx_cnt_q != RX_CNT_MAX)
		&& (rx_cnt_q >= FIRST_DATA_POS) && (widx < exp_words_q);

	// classify the beat and build the job
	always_comb begin
		rx_crc_d    = rx_crc_q;
		rx_cnt_d    = rx_cnt_q;
		hold_d      = hold_q;
		exp_words_d = exp_words_q;
		pending_d   = pending_q;
		push        = 1'b0;
		job         = '0;
		unique case (operation)
			OP_READ, OP_WRITE_ONE, OP_WRITE_HDR: begin
				rx_crc_d = CRC_SEED;
				rx_cnt_d = '0;
				hold_d   = '0;
				push     = 1'b1;
				job.crc_init = 1'b1;
				job.bytes[0] = slave_address_q;
				job.bytes[2] = start_register[15:8];
				job.bytes[3] = start_register[7:0];
				job.bytes[5] = {1'b0, register_count};
				job.nbytes   = (STEP_W+1)'(6);
				job.send_crc = 1'b1;
				exp_words_d  = '0;
				if (operation == OP_READ) begin
					pending_d    = PEND_READ;
					job.bytes[1] = FC_READ_HOLD;
					exp_words_d  = (register_count > MAX_REGS) ? MAX_REGS : register_count;
				end else if (operation == OP_WRITE_ONE) begin
					pending_d    = PEND_SINGLE;
					job.bytes[1] = FC_WRITE_ONE;
					job.bytes[4] = data_word[15:8];
					job.bytes[5] = data_word[7:0];
				end else begin
					pending_d    = PEND_MULTI;
					job.bytes[1] = FC_WRITE_MULT;
					job.bytes[6] = {register_count, 1'b0};
					job.nbytes   = (STEP_W+1)'(7);
					job.send_crc = 1'b0;
				end
			end
			OP_DATA: begin
				push         = 1'b1;
				job.bytes[0] = data_word[15:8];
				job.bytes[1] = data_word[7:0];
				job.nbytes   = (STEP_W+1)'(2);
				job.send_crc = last_item;
			end
			OP_RESP: begin
				job.is_rx = 1'b1;
				rx_crc_d  = crc_next;
				rx_cnt_d  = cnt_next;
				if (in_words) begin
					if (!dpos[0]) begin
						hold_d = rx_byte;
					end else begin
						job.has_word = 1'b1;
						job.word     = {hold_q, rx_byte};
						job.widx     = widx;
					end
				end
				if (last_item) begin
					job.has_status = 1'b1;
					job.ok         = (cnt_next >= 8'd2) && (crc_next == 16'h0000);
					rx_crc_d       = CRC_SEED;
					rx_cnt_d       = '0;
					hold_d         = '0;
					pending_d      = PEND_NONE;
				end
				push = job.has_word || job.has_status;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	assign q_push = accept && push;
	assign q_job  = job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_address_q <= 8'd1;
			rx_crc_q        <= CRC_SEED;
			rx_cnt_q        <= '0;
			hold_q          <= '0;
			exp_words_q     <= '0;
			pending_q       <= PEND_NONE;
		end else begin
			if (cfg_we) begin
				slave_address_q <= cfg_wdata;
			end
			if (accept) begin
				rx_crc_q    <= rx_crc_d;
				rx_cnt_q    <= rx_cnt_d;
				hold_q      <= hold_d;
				exp_words_q <= exp_words_d;
				pending_q   <= pending_d;
			end
		end
	end

endmodule

@@ hw/rtl/mrf_queue.sv @@
module mrf_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  mrf_pkg::job_t push_job,
	input  logic          pop,
	output logic          full,
	output logic          head_valid,
	output mrf_pkg::job_t head_job
);
	import mrf_pkg::*;

	job_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full       = (cnt_q == QCNT_W'(QDEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_job   = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

@@ hw/rtl/mrf_back.sv @@
module mrf_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          head_valid,
	input  mrf_pkg::job_t head_job,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [1:0]    result_kind,
	output logic [7:0]    tx_byte,
	output logic [15:0]   register_word,
	output logic [6:0]    word_index,
	output logic          crc_ok,
	output logic          end_of_run
);
	import mrf_pkg::*;

	logic [STEP_W-1:0] step_q;
	logic [15:0]       tx_crc_q;
	logic              out_valid_q;
	logic [1:0]        kind_q;
	logic [7:0]        txb_q;
	logic [15:0]       word_q;
	logic [6:0]        widx_q;
	logic              ok_q;
	logic              eor_q;

	logic              load;
	logic              fire;
	logic [1:0]        kind_c;
	logic [7:0]        txb_c;
	logic [15:0]       word_c;
	logic [6:0]        widx_c;
	logic              ok_c;
	logic              last_c;
	logic [15:0]       crc_base;
	logic [15:0]       crc_c;
	logic [STEP_W:0]   step_x;
	logic [STEP_W:0]   total;

	assign load     = !out_valid_q || !out_stall;
	assign fire     = load && head_valid;
	assign step_x   = {1'b0, step_q};
	assign total    = head_job.nbytes + (head_job.send_crc ? (STEP_W+1)'(2) : '0);
	assign crc_base = (head_job.crc_init && step_q == '0) ? CRC_SEED : tx_crc_q;

	// pick the result for the current step of the head job
	always_comb begin
		kind_c = KIND_TX;
		txb_c  = '0;
		word_c = '0;
		widx_c = '0;
		ok_c   = 1'b0;
		last_c = 1'b0;
		crc_c  = tx_crc_q;
		if (head_job.is_rx) begin
			if (step_q == '0 && head_job.has_word) begin
				kind_c = KIND_WORD;
				word_c = head_job.word;
				widx_c = head_job.widx;
				last_c = !head_job.has_status;
			end else begin
				kind_c = KIND_STATUS;
				ok_c   = head_job.ok;
				last_c = 1'b1;
			end
		end else begin
			last_c = (step_x == total - 1'b1);
			if (step_x < head_job.nbytes) begin
				txb_c = head_job.bytes[step_q];
				crc_c = crc_feed(crc_base, txb_c);
			end else if (step_x == head_job.nbytes) begin
				txb_c = crc_base[7:0];
				crc_c = crc_base;
			end else begin
				txb_c = crc_base[15:8];
				crc_c = CRC_SEED;
			end
		end
	end

	assign pop = fire && last_c;

	// step counter and transmit CRC
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			tx_crc_q    <= CRC_SEED;
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= head_valid;
			if (head_valid) begin
				step_q <= last_c ? '0 : step_q + 1'b1;
				if (!head_job.is_rx) begin
					tx_crc_q <= crc_c;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (fire) begin
			kind_q <= kind_c;
			txb_q  <= txb_c;
			word_q <= word_c;
			widx_q <= widx_c;
			ok_q   <= ok_c;
			eor_q  <= last_c;
		end
	end

	assign out_valid     = out_valid_q;
	assign result_kind   = kind_q;
	assign tx_byte       = txb_q;
	assign register_word = word_q;
	assign word_index    = widx_q;
	assign crc_ok        = ok_q;
	assign end_of_run    = eor_q;

endmodule

@@ hw/rtl/modbus_rtu_master_framer_core.sv @@
// An accepted beat is written into the job queue as a job, and the back end then loads
// each result of that job into its output register.
// The back end gives one result beat per cycle while out_stall is low. A request item
// yields 7 or 8 frame bytes, a data word 2 or 4, a response byte 0 to 2 results.
// A 2-entry job queue lets the front take new beats while the back drains a frame.
// Reset (arst_n low) clears all CRC, counter and pending-request state; address reg is 1.
module modbus_rtu_master_framer_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  operation,
	input  logic [15:0] start_register,
	input  logic [6:0]  register_count,
	input  logic [15:0] data_word,
	input  logic [7:0]  rx_byte,
	input  logic        last_item,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  result_kind,
	output logic [7:0]  tx_byte,
	output logic [15:0] register_word,
	output logic [6:0]  word_index,
	output logic        crc_ok,
	output logic        end_of_run
);
	import mrf_pkg::*;

	logic q_full;
	logic q_push;
	logic q_pop;
	logic q_head_valid;
	job_t q_in_job;
	job_t q_head_job;

	mrf_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.operation      (operation),
		.start_register (start_register),
		.register_count (register_count),
		.data_word      (data_word),
		.rx_byte        (rx_byte),
		.last_item      (last_item),
		.q_full         (q_full),
		.q_push         (q_push),
		.q_job          (q_in_job)
	);

	mrf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_job   (q_in_job),
		.pop        (q_pop),
		.full       (q_full),
		.head_valid (q_head_valid),
		.head_job   (q_head_job)
	);

	mrf_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (q_head_valid),
		.head_job      (q_head_job),
		.pop           (q_pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.result_kind   (result_kind),
		.tx_byte       (tx_byte),
		.register_word (register_word),
		.word_index    (word_index),
		.crc_ok        (crc_ok),
		.end_of_run    (end_of_run)
	);

endmodule
